// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int TOP_ORDER   = 10;
    localparam int NUM_ORDERS  = TOP_ORDER + 1;
    localparam int PAGE_BYTES  = 4096;
    localparam int STACK_DEPTH = 1024;

    localparam int ORDER_W = 4;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int LVL_W   = $clog2(NUM_ORDERS);
    localparam int STORE_WORDS = NUM_ORDERS * STACK_DEPTH;
    localparam int STORE_AW    = LVL_W + SLOT_W;

    localparam logic [ADDR_W-1:0] POOL_RESET = 32'h0010_0000;

    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(TOP_ORDER);

    // status codes on the result channel
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SPLIT,
        S_RESP
    } bpa_state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic pop;
        logic split;
        logic respond;
    } bpa_cmd_t;

    typedef struct packed {
        logic bad_order;
        logic is_free;
        logic found;
        logic split_more;
        logic out_free;
    } bpa_stat_t;

endpackage

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bpa_pkg::bpa_stat_t stat,
    output bpa_pkg::bpa_cmd_t  cmd
);
    import bpa_pkg::*;

    bpa_state_t state_reg;
    bpa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (stat.bad_order || stat.is_free || !stat.found) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                state_next = S_SPLIT;
            end
            S_SPLIT: begin
                if (!stat.split_more) state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECODE: cmd.decode  = 1'b1;
            S_POP:    cmd.pop     = 1'b1;
            S_SPLIT:  cmd.split   = stat.split_more;
            S_RESP:   cmd.respond = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/bpa_datapath.sv =====
module bpa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          in_kind,
    input  logic [bpa_pkg::ORDER_W-1:0]   in_order,
    input  logic [bpa_pkg::ADDR_W-1:0]    in_addr,
    input  logic                          m_tready,
    output logic                          out_valid,
    output logic [bpa_pkg::ADDR_W-1:0]    out_addr,
    output logic [bpa_pkg::STAT_W-1:0]    out_status,
    input  bpa_pkg::bpa_cmd_t             cmd,
    output bpa_pkg::bpa_stat_t            stat
);
    import bpa_pkg::*;

    logic [ADDR_W-1:0]   mem [STORE_WORDS];
    logic [ADDR_W-1:0]   rd_q;
    logic [STORE_AW-1:0] rd_addr;
    logic [STORE_AW-1:0] wr_addr;
    logic [ADDR_W-1:0]   wr_data;
    logic                wr_en;

    logic [CNT_W-1:0]    count_reg [NUM_ORDERS];
    logic [ADDR_W-1:0]   pool_base_reg;
    logic                base_live_reg;
    logic                base_hit_reg;

    logic                kind_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LVL_W-1:0]    cur_reg;
    logic [ADDR_W-1:0]   blk_reg;
    logic [STAT_W-1:0]   status_reg;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [STAT_W-1:0]   out_status_reg;

    logic                bad_order;
    logic [LVL_W-1:0]    ord_lvl;
    logic                found;
    logic [LVL_W-1:0]    found_lvl;
    logic [CNT_W-1:0]    ord_cnt;
    logic [CNT_W-1:0]    found_cnt;
    logic [CNT_W-1:0]    pop_cnt;
    logic [LVL_W-1:0]    cur_dn;
    logic [CNT_W-1:0]    dn_cnt;
    logic [ADDR_W-1:0]   half_size;
    logic [ADDR_W-1:0]   half_addr;
    logic                ord_full;
    logic                dn_full;

    assign bad_order = (order_reg > ORDER_W'(TOP_ORDER));

    assign ord_lvl   = bad_order ? '0 : order_reg[LVL_W-1:0];
    assign ord_cnt   = count_reg[ord_lvl];
    assign ord_full  = (ord_cnt >= CNT_W'(STACK_DEPTH));

    // first non-empty stack at or above the requested order
    always_comb begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (!found && (LVL_W'(i) >= ord_lvl) && (count_reg[i] != '0)) begin
                found     = 1'b1;
                found_lvl = LVL_W'(i);
            end
        end
    end
    assign found_cnt = count_reg[found_lvl];
    assign pop_cnt   = found_cnt - 1'b1;

    assign cur_dn    = cur_reg - 1'b1;
    assign dn_cnt    = count_reg[cur_dn];
    assign dn_full   = (dn_cnt >= CNT_W'(STACK_DEPTH));
    assign half_size = ADDR_W'(PAGE_BYTES) << cur_dn;
    assign half_addr = blk_reg + half_size;

    assign stat.bad_order  = bad_order;
    assign stat.is_free    = (kind_reg == KIND_FREE);
    assign stat.found      = found;
    assign stat.split_more = (cur_reg > order_reg[LVL_W-1:0]);
    assign stat.out_free   = !out_valid_reg || m_tready;

    // memory port control
    always_comb begin
        rd_addr = {found_lvl, pop_cnt[SLOT_W-1:0]};
        wr_en   = 1'b0;
        wr_addr = {ord_lvl, ord_cnt[SLOT_W-1:0]};
        wr_data = addr_reg;
        if (cmd.decode && !bad_order && kind_reg == KIND_FREE && !ord_full) begin
            wr_en = 1'b1;
        end else if (cmd.split) begin
            wr_addr = {cur_dn, dn_cnt[SLOT_W-1:0]};
            wr_data = half_addr;
            wr_en   = !dn_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // counts and the top-order base entry, which lives in a register until overwritten
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ORDERS; i++)
                count_reg[i] <= (i == TOP_ORDER) ? CNT_W'(1) : '0;
            pool_base_reg        <= POOL_RESET;
            base_live_reg        <= 1'b1;
        end else if (cfg_wen) begin
            for (int i = 0; i < NUM_ORDERS; i++)
                count_reg[i] <= (i == TOP_ORDER) ? CNT_W'(1) : '0;
            pool_base_reg        <= cfg_wdata;
            base_live_reg        <= 1'b1;
        end else begin
            if (wr_en) begin
                count_reg[wr_addr[STORE_AW-1:SLOT_W]] <=
                    count_reg[wr_addr[STORE_AW-1:SLOT_W]] + 1'b1;
                if (wr_addr == {TOP_LVL, SLOT_W'(0)}) base_live_reg <= 1'b0;
            end
            if (cmd.decode && !bad_order && kind_reg == KIND_ALLOC && found) begin
                count_reg[found_lvl] <= pop_cnt;
            end
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_kind;
            order_reg <= in_order;
            addr_reg  <= in_addr;
        end
        if (cmd.decode) begin
            blk_reg      <= '0;
            cur_reg      <= found_lvl;
            base_hit_reg <= base_live_reg && (rd_addr == {TOP_LVL, SLOT_W'(0)});
            if (bad_order) begin
                status_reg <= ST_BAD_ORDER;
            end else if (kind_reg == KIND_FREE) begin
                status_reg <= ord_full ? ST_FULL : ST_OK;
            end else begin
                status_reg <= found ? ST_OK : ST_EMPTY;
            end
        end
        if (cmd.pop) begin
            blk_reg <= base_hit_reg ? pool_base_reg : rd_q;
        end
        if (cmd.split) begin
            cur_reg <= cur_dn;
            if (dn_full) status_reg <= ST_FULL;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.respond) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            out_addr_reg   <= blk_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

// ===== rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator: one LIFO free stack per order 0..10, pages of 4 KiB.
// Input channel s_*: tuser carries the kind (0 allocate, 1 free), tdata the
// order and the block address. Result channel m_*: tdata carries the granted
// address and a 2-bit status (ok, no free block, bad order, stack full).
// Config: a pulse on cfg_wen loads pool_base and rebuilds the stacks so only
// the top order holds one block at pool_base. Write it only while idle.
// One item is in flight at a time; the next is accepted the cycle after its
// result is loaded. A free, a bad order or a failed allocation goes from
// decode straight to the result; an allocation pops its block and then splits
// it level by level (up to 10 levels) down to the requested order. The split
// sequencer writes one half per cycle through the single write port of the
// stack memory.
// Reset (aresetn low, synchronous) empties all stacks but the top one, loads
// pool_base with 0x100000 and drops any pending result. The stack memory
// itself is not cleared and needs no clearing pass.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile, and it waits before loading its own result.
module buddy_page_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] order, [35:4] block_address, rest zero
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] granted_address, [33:32] status, rest zero
);
    import bpa_pkg::*;

    bpa_cmd_t            cmd;
    bpa_stat_t           stat;
    logic [ADDR_W-1:0]   out_addr;
    logic [STAT_W-1:0]   out_status;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_kind    (s_tuser[0]),
        .in_order   (s_tdata[3:0]),
        .in_addr    (s_tdata[35:4]),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_addr   (out_addr),
        .out_status (out_status),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = {6'd0, out_status, out_addr};

endmodule

// ===== rtl/bpa_checker.sv =====
module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wen,
    input logic [31:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import bpa_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == ST_EMPTY || m_tdata[33:32] == ST_BAD_ORDER)
        |-> m_tdata[31:0] == '0)
        else $error("failed request returned an address");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:34] == '0)
        else $error("result padding not zero");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);

// ===== tb/buddy_page_allocator_unit_test.sv =====
`timescale 1ns / 1ps

module buddy_page_allocator_unit_test;
    import bpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TDATA_PAD      = 40 - ORDER_W - ADDR_W;

    typedef struct packed {
        logic               kind;
        logic [ORDER_W-1:0] order;
        logic [ADDR_W-1:0]  addr;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        logic [STAT_W-1:0] status;
    } response_t;

    typedef struct packed {
        request_t  req;
        logic      typed;
        response_t want;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [3:0] order, [35:4] block_address, rest zero
    logic [0:0]  s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] granted_address, [33:32] status, rest zero

    buddy_page_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow of the free stacks
    logic [ADDR_W-1:0] free_pages [NUM_ORDERS][STACK_DEPTH];
    int unsigned       free_depth [NUM_ORDERS];

    response_t     pending_responses[$];
    request_t      held_blocks[$];
    directed_row_t directed_rows[$];

    int  mismatch_count = 0;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;
    bit  hold_request = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void rebuild_free_pages(input logic [ADDR_W-1:0] base);
        for (int k = 0; k < NUM_ORDERS; k++)
            free_depth[k] = 0;
        free_pages[TOP_ORDER][0] = base;
        free_depth[TOP_ORDER] = 1;
    endfunction

    function automatic bit push_free_page(input int lvl, input logic [ADDR_W-1:0] addr);
        if (free_depth[lvl] >= STACK_DEPTH)
            return 1'b0;
        free_pages[lvl][free_depth[lvl]] = addr;
        free_depth[lvl]++;
        return 1'b1;
    endfunction

    function automatic response_t predict_allocator_response(input request_t req);
        response_t         res;
        int                lvl;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] half;
        res.granted = '0;
        res.status  = ST_OK;
        if (int'(req.order) > TOP_ORDER) begin
            res.status = ST_BAD_ORDER;
        end else if (req.kind == KIND_FREE) begin
            if (!push_free_page(int'(req.order), req.addr))
                res.status = ST_FULL;
        end else begin
            lvl = int'(req.order);
            while (lvl <= TOP_ORDER && free_depth[lvl] == 0)
                lvl++;
            if (lvl > TOP_ORDER) begin
                res.status = ST_EMPTY;
            end else begin
                free_depth[lvl]--;
                blk = free_pages[lvl][free_depth[lvl]];
                // split down, upper half of each level goes back on its stack
                while (lvl > int'(req.order)) begin
                    lvl--;
                    half = blk + (ADDR_W'(PAGE_BYTES) << lvl);
                    if (!push_free_page(lvl, half))
                        res.status = ST_FULL;
                end
                res.granted = blk;
            end
        end
        return res;
    endfunction

    // mostly short, a few long; none in steady stretches
    function automatic int pick_stretch(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input request_t req, input bit use_given,
                                input response_t given, output response_t predicted);
        int gap;
        gap = pick_stretch(sender_steady);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {{TDATA_PAD{1'b0}}, req.addr, req.order};
        s_tuser  = req.kind;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_allocator_response(req);
        pending_responses.push_back(use_given ? given : predicted);
        @(negedge aclk);
    endtask

    task automatic drain_responses();
        s_tvalid = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_pool_base(input logic [ADDR_W-1:0] base);
        cfg_wdata = base;
        cfg_wen   = 1'b1;
        @(negedge aclk);
        cfg_wen   = 1'b0;
        rebuild_free_pages(base);
        held_blocks.delete();
        @(negedge aclk);
    endtask

    task automatic add_row(input logic kind, input logic [ORDER_W-1:0] order,
                           input logic [ADDR_W-1:0] addr, input logic typed,
                           input logic [ADDR_W-1:0] granted, input logic [STAT_W-1:0] status);
        directed_row_t row;
        row.req.kind     = kind;
        row.req.order    = order;
        row.req.addr     = addr;
        row.typed        = typed;
        row.want.granted = granted;
        row.want.status  = status;
        directed_rows.push_back(row);
    endtask

    task automatic run_mixed_phase(input int count);
        request_t  req;
        response_t res;
        int        r;
        int        idx;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                req.kind  = 1'($urandom_range(0, 1));
                req.order = ORDER_W'($urandom_range(0, 15));
                req.addr  = $urandom;
            end else if (r < 60 || held_blocks.size() == 0) begin
                req.kind  = KIND_ALLOC;
                req.order = ($urandom_range(0, 9) < 7) ? ORDER_W'($urandom_range(0, 4))
                                                       : ORDER_W'($urandom_range(0, TOP_ORDER));
                req.addr  = $urandom;
            end else begin
                idx = $urandom_range(0, held_blocks.size() - 1);
                req = held_blocks[idx];
                held_blocks.delete(idx);
            end
            send_request(req, 1'b0, '0, res);
            if (req.kind == KIND_ALLOC && (res.status == ST_OK || res.status == ST_FULL))
                held_blocks.push_back('{KIND_FREE, req.order, res.granted});
        end
    endtask

    // pile frees onto one order until its stack overflows, then churn it
    task automatic run_fill_phase(input int lvl);
        request_t  req;
        response_t res;
        for (int i = 0; i < STACK_DEPTH + 6; i++) begin
            req = '{KIND_FREE, ORDER_W'(lvl), $urandom};
            send_request(req, 1'b0, '0, res);
        end
        for (int i = 0; i < 80; i++) begin
            req = '{1'($urandom_range(0, 1)), ORDER_W'(lvl), $urandom};
            send_request(req, 1'b0, '0, res);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        response_t want;
        response_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.granted = m_tdata[ADDR_W-1:0];
            got.status  = m_tdata[ADDR_W+STAT_W-1:ADDR_W];
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: addr=%h status=%0d",
                             got.granted, got.status);
            end else begin
                want = pending_responses.pop_front();
                if (got.granted !== want.granted || got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                                 want.granted, want.status, got.granted, got.status);
                end
            end
        end
    end

    // receiver: random backpressure plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_tready     = 1'b0;
            end else begin
                if (stall_left == 0)
                    stall_left = pick_stretch(receiver_steady);
                if (stall_left > 0) begin
                    m_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || !aresetn)
                idle = 0;
            else
                idle++;
        end
        $display("** buddy_page_allocator_unit: FAILED **");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] pool_values [4];
        response_t         res;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        rebuild_free_pages(POOL_RESET);
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        add_row(KIND_ALLOC, 4'd15, 32'h0,          1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_FREE,  4'd15, 32'hFFFF_FFFF,  1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_ALLOC, 4'd10, 32'hFFFF_FFFF,  1'b1, POOL_RESET,    ST_OK);
        add_row(KIND_ALLOC, 4'd0,  32'h0,          1'b1, 32'h0,         ST_EMPTY);
        add_row(KIND_ALLOC, 4'd10, 32'h0,          1'b1, 32'h0,         ST_EMPTY);
        add_row(KIND_FREE,  4'd10, POOL_RESET,     1'b1, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd0,  32'h0,          1'b1, POOL_RESET,    ST_OK);
        add_row(KIND_ALLOC, 4'd0,  32'h0,          1'b0, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd1,  32'h0,          1'b0, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd9,  32'h0,          1'b0, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd10, 32'h0,          1'b1, 32'h0,         ST_EMPTY);
        add_row(KIND_FREE,  4'd0,  32'h0,          1'b1, 32'h0,         ST_OK);
        // address zero is a legal grant
        add_row(KIND_ALLOC, 4'd0,  32'h0,          1'b1, 32'h0,         ST_OK);
        add_row(KIND_FREE,  4'd7,  32'hFFFF_FFFF,  1'b1, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd7,  32'h0,          1'b1, 32'hFFFF_FFFF, ST_OK);
        add_row(KIND_FREE,  4'd11, 32'h0,          1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_ALLOC, 4'd12, 32'h0,          1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_ALLOC, 4'd13, 32'h0,          1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_FREE,  4'd14, 32'h0,          1'b1, 32'h0,         ST_BAD_ORDER);
        add_row(KIND_FREE,  4'd3,  32'hAAAA_AAAA,  1'b1, 32'h0,         ST_OK);
        add_row(KIND_FREE,  4'd3,  32'h5555_5555,  1'b1, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd2,  32'h0,          1'b0, 32'h0,         ST_OK);
        add_row(KIND_ALLOC, 4'd3,  32'h0,          1'b1, 32'h5555_5555, ST_OK);
        add_row(KIND_ALLOC, 4'd3,  32'h0,          1'b1, 32'hAAAA_AAAA, ST_OK);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want, res);
        drain_responses();

        // extremes first; the all-ones base wraps on the first split
        pool_values[0] = 32'h0;
        pool_values[1] = 32'hFFFF_FFFF;
        pool_values[2] = $urandom;
        pool_values[3] = POOL_RESET;
        for (int p = 0; p < 4; p++) begin
            write_pool_base(pool_values[p]);
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                sender_steady = 1'b1;
                hold_request  = 1'b1;
            end
            run_mixed_phase(130);
            drain_responses();
        end

        write_pool_base($urandom);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        run_fill_phase($urandom_range(0, TOP_ORDER));
        drain_responses();
        repeat (20) @(negedge aclk);

        if (pending_responses.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("** buddy_page_allocator_unit: PASSED **");
        else
            $display("** buddy_page_allocator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== buddy_page_allocator_unit.f =====
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/buddy_page_allocator_unit.sv
rtl/bpa_checker.sv
tb/buddy_page_allocator_unit_test.sv
